FILE: rtl/clt_pkg.sv
`default_nettype none

package clt_pkg;

	// fixed widths of the result fields
	localparam int RX_CHAR_W      = 8;
	localparam int FIELD_INDEX_W  = 3;
	localparam int FIELD_START_W  = 7;
	localparam int FIELD_LENGTH_W = 7;
	localparam int FIELD_VALUE_W  = 32;
	localparam int FIELD_COUNT_W  = 3;

	typedef logic [RX_CHAR_W-1:0] char_t;

	// character codes
	localparam char_t CH_BS      = 8'd8;
	localparam char_t CH_CR      = 8'd13;
	localparam char_t CH_SPACE   = 8'd32;
	localparam char_t CH_DIGIT_0 = 8'd48;
	localparam char_t CH_DIGIT_9 = 8'd57;
	localparam char_t CH_UPPER_A = 8'd65;
	localparam char_t CH_UPPER_Z = 8'd90;
	localparam char_t CH_LOWER_A = 8'd97;
	localparam char_t CH_LOWER_Z = 8'd122;
	localparam char_t CH_DEL     = 8'd127;

	function automatic logic is_digit(input char_t c);
		return (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
	endfunction

	function automatic logic is_letter(input char_t c);
		return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
			((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
	endfunction

endpackage

`default_nettype wire

FILE: rtl/clt_ram.sv
`default_nettype none

module clt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 80
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output      logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/command_line_tokenizer_unit.sv
`default_nettype none

// command line tokenizer
//
// input: one character code on rx_char, taken at a clock edge where start is
// high and busy is low. while the line is being edited every character is
// taken as offered: backspace/delete drop the last character, other control
// codes are ignored, codes from space up (also a delete on an empty line) go
// into the line memory. a carriage return, or the line reaching LINE_CHARS
// characters, finishes the line. busy then rises and the line memory is swept
// one character per cycle, with registered read data, to find the fields.
// output: one item per field, or one empty item with no_fields set, each shown
// for exactly one cycle with strobe high; last marks the final item of a line.
// the receiver cannot hold items off, so there is no back-pressure path.
// after the sweep the items come out one per cycle. a return on an empty line
// skips the sweep and goes straight to the empty item.
// reset clears the character count and the sequencer; the line memory is not
// cleared, only positions written in the current line are ever read.

module command_line_tokenizer_unit #(
	parameter int LINE_CHARS      = 80,
	parameter int MAX_FIELD_COUNT = 6
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output      logic        busy,
	input  wire logic [7:0]  rx_char,
	output      logic        strobe,
	output      logic [2:0]  field_index,
	output      logic        field_kind,
	output      logic [6:0]  field_start,
	output      logic [6:0]  field_length,
	output      logic [31:0] field_value,
	output      logic [2:0]  field_count,
	output      logic        no_fields,
	output      logic        last
);

	localparam int POS_W = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;
	localparam int CNT_W = $clog2(LINE_CHARS + 1);
	localparam int FI_W  = (MAX_FIELD_COUNT > 1) ? $clog2(MAX_FIELD_COUNT) : 1;
	localparam int NF_W  = $clog2(MAX_FIELD_COUNT + 1);
	localparam int VW    = clt_pkg::FIELD_VALUE_W;
	localparam int OIW   = clt_pkg::FIELD_INDEX_W;
	localparam int OSW   = clt_pkg::FIELD_START_W;
	localparam int OLW   = clt_pkg::FIELD_LENGTH_W;
	localparam int OCW   = clt_pkg::FIELD_COUNT_W;

	localparam logic [CNT_W-1:0] LINE_FULL = CNT_W'(LINE_CHARS);
	localparam logic [NF_W-1:0]  NF_MAX    = NF_W'(MAX_FIELD_COUNT);

	// sequencer codes
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] count_q;     // characters in the line being edited
	logic [CNT_W-1:0] len_q;       // length of the finished line
	logic [CNT_W-1:0] rd_ptr_q;    // next position to read in the sweep
	logic             valid_s1;    // read data valid
	logic             last_s1;     // read data is the final character
	logic [POS_W-1:0] pos_s1;      // position of the read data
	logic [NF_W-1:0]  nf_q;        // fields started so far
	logic             inside_q;    // previous character belonged to a field
	logic [FI_W-1:0]  cur_idx_q;   // field being extended
	logic             cur_kind_q;
	logic [CNT_W-1:0] cur_len_q;
	logic [VW-1:0]    cur_val_q;
	logic [FI_W-1:0]  e_q;         // field being sent out

	// per-field results collected by the sweep
	logic [POS_W-1:0] fstart_q [MAX_FIELD_COUNT];
	logic             fkind_q  [MAX_FIELD_COUNT];
	logic [CNT_W-1:0] flen_q   [MAX_FIELD_COUNT];
	logic [VW-1:0]    fval_q   [MAX_FIELD_COUNT];

	// result register
	logic             strobe_q;
	logic [OIW-1:0]   o_index_q;
	logic             o_kind_q;
	logic [OSW-1:0]   o_start_q;
	logic [OLW-1:0]   o_len_q;
	logic [VW-1:0]    o_val_q;
	logic [OCW-1:0]   o_count_q;
	logic             o_none_q;
	logic             o_last_q;

	// ---------------------------------------------------------------
	// line editing
	// ---------------------------------------------------------------
	logic             accept;
	logic             is_erase;
	logic             is_cr;
	logic             is_store;
	logic [CNT_W-1:0] count_inc;
	logic             finish;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign is_erase  = ((rx_char == clt_pkg::CH_BS) || (rx_char == clt_pkg::CH_DEL)) &&
		(count_q != '0);
	assign is_cr     = (rx_char == clt_pkg::CH_CR);
	assign is_store  = !is_erase && (rx_char >= clt_pkg::CH_SPACE);
	assign count_inc = count_q + CNT_W'(1);
	assign finish    = accept && (is_cr || (is_store && (count_inc == LINE_FULL)));

	// ---------------------------------------------------------------
	// line memory
	// ---------------------------------------------------------------
	logic             rd_en;
	logic [7:0]       rd_data;

	assign rd_en = (state_q == ST_SCAN) && (rd_ptr_q != len_q);

	clt_ram #(
		.WIDTH(8),
		.DEPTH(LINE_CHARS)
	) u_line_ram (
		.clk  (clk),
		.we   (accept && is_store),
		.waddr(count_q[POS_W-1:0]),
		.wdata(rx_char),
		.re   (rd_en),
		.raddr(rd_ptr_q[POS_W-1:0]),
		.rdata(rd_data)
	);

	// ---------------------------------------------------------------
	// field scan on read data
	// ---------------------------------------------------------------
	logic             d_digit;
	logic             d_alnum;
	logic             tail;
	logic             fld_open;    // a new field starts here
	logic             fld_ext;     // current field grows by this character
	logic [VW-1:0]    d_val;
	logic [VW-1:0]    ext_val;
	logic [VW-1:0]    new_val;
	logic [CNT_W-1:0] new_len;
	logic [FI_W-1:0]  fld_widx;

	assign d_digit = clt_pkg::is_digit(rd_data);
	assign d_alnum = d_digit || clt_pkg::is_letter(rd_data);
	// once every field is started the last one swallows the rest of the line
	assign tail    = (nf_q == NF_MAX);
	assign fld_open = valid_s1 && !tail && d_alnum && !inside_q;
	assign fld_ext  = valid_s1 && (tail || (d_alnum && inside_q));
	assign d_val   = VW'(rd_data) - VW'(clt_pkg::CH_DIGIT_0);
	// times ten as two shifts
	assign ext_val = (cur_val_q << 3) + (cur_val_q << 1) + d_val;

	always_comb begin
		if (fld_open) begin
			fld_widx = FI_W'(nf_q);
			new_len  = CNT_W'(1);
			new_val  = d_digit ? d_val : '0;
		end else begin
			fld_widx = cur_idx_q;
			new_len  = cur_len_q + CNT_W'(1);
			new_val  = cur_kind_q ? ext_val : cur_val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fld_open || fld_ext) begin
			flen_q[fld_widx] <= new_len;
			fval_q[fld_widx] <= new_val;
		end
		if (fld_open) begin
			fstart_q[fld_widx] <= pos_s1;
			fkind_q[fld_widx]  <= d_digit;
		end
		if (fld_open) begin
			cur_idx_q  <= fld_widx;
			cur_kind_q <= d_digit;
		end
		if (fld_open || fld_ext) begin
			cur_len_q <= new_len;
			cur_val_q <= new_val;
		end
		pos_s1  <= rd_ptr_q[POS_W-1:0];
		last_s1 <= (rd_ptr_q + CNT_W'(1)) == len_q;
	end

	// ---------------------------------------------------------------
	// sequencer and control registers
	// ---------------------------------------------------------------
	logic e_last;

	assign e_last = (NF_W'(e_q) + NF_W'(1)) == nf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			len_q    <= '0;
			rd_ptr_q <= '0;
			valid_s1 <= 1'b0;
			nf_q     <= '0;
			inside_q <= 1'b0;
			e_q      <= '0;
			strobe_q <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
			strobe_q <= (state_q == ST_EMIT);
			unique case (state_q)
				ST_IDLE: begin
					if (finish) begin
						count_q  <= '0;
						len_q    <= is_cr ? count_q : count_inc;
						rd_ptr_q <= '0;
						nf_q     <= '0;
						inside_q <= 1'b0;
						e_q      <= '0;
						// an empty line goes straight to the empty item
						state_q  <= (is_cr && (count_q == '0)) ? ST_EMIT : ST_SCAN;
					end else if (accept && is_erase) begin
						count_q <= count_q - CNT_W'(1);
					end else if (accept && is_store) begin
						count_q <= count_inc;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						rd_ptr_q <= rd_ptr_q + CNT_W'(1);
					end
					if (fld_open) begin
						nf_q     <= nf_q + NF_W'(1);
						inside_q <= 1'b1;
					end else if (valid_s1 && !tail && !d_alnum) begin
						inside_q <= 1'b0;
					end
					if (valid_s1 && last_s1) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					e_q <= e_q + FI_W'(1);
					if ((nf_q == '0) || e_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT) begin
			if (nf_q == '0) begin
				o_index_q <= '0;
				o_kind_q  <= 1'b0;
				o_start_q <= '0;
				o_len_q   <= '0;
				o_val_q   <= '0;
				o_count_q <= '0;
				o_none_q  <= 1'b1;
				o_last_q  <= 1'b1;
			end else begin
				o_index_q <= OIW'(e_q);
				o_kind_q  <= fkind_q[e_q];
				o_start_q <= OSW'(fstart_q[e_q]);
				o_len_q   <= OLW'(flen_q[e_q]);
				o_val_q   <= fval_q[e_q];
				o_count_q <= OCW'(nf_q);
				o_none_q  <= 1'b0;
				o_last_q  <= e_last;
			end
		end
	end

	assign strobe       = strobe_q;
	assign field_index  = o_index_q;
	assign field_kind   = o_kind_q;
	assign field_start  = o_start_q;
	assign field_length = o_len_q;
	assign field_value  = o_val_q;
	assign field_count  = o_count_q;
	assign no_fields    = o_none_q;
	assign last         = o_last_q;

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("item sent without a finished line");

	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |=> !strobe)
		else $error("item sent after the last item of a line");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && no_fields) |-> last)
		else $error("empty item not marked last");

	a_count_below_full: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> (count_q < LINE_FULL))
		else $error("line count reached full length while editing");

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 100ps

// checks command_line_tokenizer_unit against its own line editor and field scanner
// directed rows come first, some with their result typed in, then random lines

module testbench;

	localparam int LINE_CHARS    = 80;
	localparam int FIELD_LIMIT   = 6;
	localparam int ITEMS_TOTAL   = 220;
	localparam int MAX_GAP       = 18;
	localparam int STALL_LIMIT   = 2000; // cycles with no item and no result
	localparam int SETTLE_CYCLES = 100;  // margin after the last result, above the longest line sweep
	localparam int REPORT_LIMIT  = 10;

	// one result of the block, members in port order
	typedef struct packed {
		logic [clt_pkg::FIELD_INDEX_W-1:0]  idx;
		logic                               kind;
		logic [clt_pkg::FIELD_START_W-1:0]  pos;
		logic [clt_pkg::FIELD_LENGTH_W-1:0] len;
		logic [clt_pkg::FIELD_VALUE_W-1:0]  value;
		logic [clt_pkg::FIELD_COUNT_W-1:0]  cnt;
		logic                               empty;
		logic                               last;
	} field_t;

	// one row of the directed table
	typedef struct {
		clt_pkg::char_t ch;
		bit             typed;
		field_t         res;
	} row_t;

	typedef enum {LINE_WORDS, LINE_FULL, LINE_NOISE} line_shape_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [7:0]  rx_char;
	logic        strobe;
	logic [2:0]  field_index;
	logic        field_kind;
	logic [6:0]  field_start;
	logic [6:0]  field_length;
	logic [31:0] field_value;
	logic [2:0]  field_count;
	logic        no_fields;
	logic        last;

	// a typed-in expectation travels with the item it belongs to
	bit     row_typed;
	field_t row_result;

	// shadow of the line being edited
	clt_pkg::char_t line_mem [LINE_CHARS];
	int unsigned    line_len;

	field_t         expected_fields [$]; // fields still to come from the block, oldest first
	field_t         new_fields [$];      // fields produced by the latest item
	clt_pkg::char_t line_chars [$];      // characters of the random line being sent
	row_t           plan [$];

	int mismatches;
	int results_checked;
	int chars_sent;
	int lines_closed;
	int full_lines;
	int capped_lines;
	int stall_cycles;

	command_line_tokenizer_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.rx_char      (rx_char),
		.strobe       (strobe),
		.field_index  (field_index),
		.field_kind   (field_kind),
		.field_start  (field_start),
		.field_length (field_length),
		.field_value  (field_value),
		.field_count  (field_count),
		.no_fields    (no_fields),
		.last         (last)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// character classes
	function automatic bit is_digit_code(clt_pkg::char_t c);
		return (c >= clt_pkg::CH_DIGIT_0) && (c <= clt_pkg::CH_DIGIT_9);
	endfunction

	function automatic bit is_word_code(clt_pkg::char_t c);
		return is_digit_code(c) ||
			((c >= clt_pkg::CH_UPPER_A) && (c <= clt_pkg::CH_UPPER_Z)) ||
			((c >= clt_pkg::CH_LOWER_A) && (c <= clt_pkg::CH_LOWER_Z));
	endfunction

	function automatic field_t make_field(int idx, bit kind, int pos, int len,
			logic [31:0] value, int cnt, bit empty, bit last_one);
		field_t f;
		f.idx   = idx[clt_pkg::FIELD_INDEX_W-1:0];
		f.kind  = kind;
		f.pos   = pos[clt_pkg::FIELD_START_W-1:0];
		f.len   = len[clt_pkg::FIELD_LENGTH_W-1:0];
		f.value = value;
		f.cnt   = cnt[clt_pkg::FIELD_COUNT_W-1:0];
		f.empty = empty;
		f.last  = last_one;
		return f;
	endfunction

	function automatic string show_field(field_t f);
		return $sformatf("idx %0d kind %0d pos %0d len %0d value %0d count %0d empty %0d last %0d",
			f.idx, f.kind, f.pos, f.len, f.value, f.cnt, f.empty, f.last);
	endfunction

	// scan the finished line and queue one field per word up to the field limit, or the empty result
	task automatic close_line();
		int unsigned starts [FIELD_LIMIT];
		bit          kinds [FIELD_LIMIT];
		int unsigned len, found, f, i, n;
		bit          in_word;
		logic [31:0] acc;
		len = line_len;
		line_len = 0;
		found = 0;
		in_word = 1'b0;
		lines_closed++;
		// a word starts at a letter or digit after a delimiter; stop at the field limit
		for (i = 0; i < len && found < FIELD_LIMIT; i++) begin
			if (is_word_code(line_mem[i])) begin
				if (!in_word) begin
					starts[found] = i;
					kinds[found] = is_digit_code(line_mem[i]);
					found++;
					in_word = 1'b1;
				end
			end else begin
				in_word = 1'b0;
			end
		end
		if (found == 0) begin
			new_fields.push_back(make_field(0, 1'b0, 0, 0, 32'd0, 0, 1'b1, 1'b1));
		end else begin
			if (found == FIELD_LIMIT)
				capped_lines++;
			for (f = 0; f < found; f++) begin
				n = 0;
				// once the limit is hit the final field swallows the rest of the line
				if (f == found - 1 && found == FIELD_LIMIT)
					n = len - starts[f];
				else
					while (starts[f] + n < len && is_word_code(line_mem[starts[f] + n]))
						n++;
				acc = 32'd0;
				// every character counts, delimiters too, and the sum wraps at 32 bits
				if (kinds[f])
					for (i = 0; i < n; i++)
						acc = acc * 32'd10 + 32'(line_mem[starts[f] + i]) -
							32'(clt_pkg::CH_DIGIT_0);
				new_fields.push_back(make_field(f, kinds[f], starts[f], n, acc, found, 1'b0,
					f == found - 1));
			end
		end
	endtask

	// line editing for one accepted character
	task automatic take_char(clt_pkg::char_t c);
		if ((c == clt_pkg::CH_BS || c == clt_pkg::CH_DEL) && line_len != 0) begin
			line_len--;
		end else if (c == clt_pkg::CH_CR) begin
			close_line();
		end else if (c >= clt_pkg::CH_SPACE) begin
			// a delete on an empty line lands here and is kept as a delimiter
			line_mem[line_len] = c;
			line_len++;
			if (line_len == LINE_CHARS) begin
				full_lines++;
				close_line();
			end
		end
	endtask

	task automatic flag_mismatch(string what, field_t got, bit have_want, field_t want);
		mismatches++;
		if (mismatches <= REPORT_LIMIT) begin
			$display("mismatch at %0t: %s", $realtime, what);
			if (have_want)
				$display("  expected %s", show_field(want));
			$display("  actual   %s", show_field(got));
		end
	endtask

	// results and accepted items, both sampled on the rising edge
	always @(posedge clk) begin : watch_ports
		field_t got;
		field_t want;
		if (arst_n) begin
			if (strobe === 1'b1) begin
				got = {field_index, field_kind, field_start, field_length, field_value,
					field_count, no_fields, last};
				results_checked++;
				if (expected_fields.size() == 0) begin
					flag_mismatch("result with no field pending", got, 1'b0, got);
				end else begin
					want = expected_fields.pop_front();
					if (got !== want)
						flag_mismatch("field differs", got, 1'b1, want);
				end
			end
			if (start && busy === 1'b0) begin
				take_char(rx_char);
				// a typed-in row stands in for the scanner on its single result
				if (row_typed)
					expected_fields.push_back(row_result);
				else
					foreach (new_fields[k])
						expected_fields.push_back(new_fields[k]);
				new_fields.delete();
			end
		end
	end

	// watchdog on stalls
	always @(posedge clk) begin
		if (!arst_n || (start && busy === 1'b0) || strobe === 1'b1)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("no item and no result for %0d cycles", STALL_LIMIT);
			$display("testbench: errors");
			$finish;
		end
	end

	// present one item after a random gap (none when no_gaps is set) and hold it until the block takes it
	task automatic drive_char(clt_pkg::char_t c, bit no_gaps, bit typed, field_t res);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		rx_char    <= c;
		row_typed  <= typed;
		row_result <= res;
		do @(posedge clk); while (busy !== 1'b0);
		if (c >= clt_pkg::CH_SPACE || c == clt_pkg::CH_BS || c == clt_pkg::CH_CR)
			chars_sent++;
	endtask

	// sender stands still until every queued field has come out
	task automatic wait_for_results();
		start <= 1'b0;
		do @(posedge clk); while (expected_fields.size() != 0);
	endtask

	task automatic add_row(clt_pkg::char_t c, bit typed = 1'b0, field_t res = '0);
		plan.push_back('{c, typed, res});
	endtask

	function automatic clt_pkg::char_t pick_delim();
		case ($urandom_range(0, 4))
			0: return clt_pkg::CH_SPACE;
			1: return clt_pkg::char_t'($urandom_range(clt_pkg::CH_SPACE + 1,
				clt_pkg::CH_DIGIT_0 - 1));
			2: return clt_pkg::char_t'($urandom_range(clt_pkg::CH_DIGIT_9 + 1,
				clt_pkg::CH_UPPER_A - 1));
			3: begin
				if ($urandom_range(0, 1))
					return clt_pkg::char_t'($urandom_range(clt_pkg::CH_UPPER_Z + 1,
						clt_pkg::CH_LOWER_A - 1));
				return clt_pkg::char_t'($urandom_range(clt_pkg::CH_LOWER_Z + 1,
					clt_pkg::CH_DEL - 1));
			end
			default: return clt_pkg::char_t'($urandom_range(128, 255));
		endcase
	endfunction

	function automatic clt_pkg::char_t pick_word_char(bit numeric);
		if (numeric)
			return clt_pkg::char_t'($urandom_range(clt_pkg::CH_DIGIT_0, clt_pkg::CH_DIGIT_9));
		if ($urandom_range(0, 1))
			return clt_pkg::char_t'($urandom_range(clt_pkg::CH_UPPER_A, clt_pkg::CH_UPPER_Z));
		return clt_pkg::char_t'($urandom_range(clt_pkg::CH_LOWER_A, clt_pkg::CH_LOWER_Z));
	endfunction

	// control codes the editor drops
	function automatic clt_pkg::char_t pick_ignored();
		clt_pkg::char_t c;
		c = clt_pkg::char_t'($urandom_range(0, clt_pkg::CH_SPACE - 1));
		if (c == clt_pkg::CH_BS || c == clt_pkg::CH_CR)
			c = clt_pkg::char_t'(clt_pkg::CH_SPACE - 1);
		return c;
	endfunction

	// words of letters and digits between delimiter runs, with edits and noise mixed in
	task automatic build_line(line_shape_t shape);
		int unsigned words, wlen, stored, w;
		bit          numeric;
		line_chars.delete();
		stored = 0;
		if (shape == LINE_NOISE) begin
			repeat ($urandom_range(4, 14))
				line_chars.push_back(clt_pkg::char_t'($urandom_range(0, 255)));
			line_chars.push_back(clt_pkg::CH_CR);
		end else begin
			if ($urandom_range(0, 5) == 0) begin
				line_chars.push_back(clt_pkg::CH_DEL);
				stored++;
			end
			words = (shape == LINE_FULL) ? LINE_CHARS : $urandom_range(0, 8);
			for (w = 0; w < words && stored < LINE_CHARS; w++) begin
				repeat ($urandom_range(w == 0 ? 0 : 1, 3)) begin
					line_chars.push_back(pick_delim());
					stored++;
				end
				numeric = 1'($urandom_range(0, 1));
				// long digit runs push the value past 32 bits
				wlen = (numeric && $urandom_range(0, 4) == 0) ?
					$urandom_range(10, 14) : $urandom_range(1, 6);
				line_chars.push_back(pick_word_char(numeric));
				stored++;
				repeat (wlen - 1) begin
					line_chars.push_back(pick_word_char($urandom_range(0, 3) == 0 ?
						!numeric : numeric));
					stored++;
					if (shape != LINE_FULL && $urandom_range(0, 11) == 0) begin
						line_chars.push_back($urandom_range(0, 1) ?
							clt_pkg::CH_BS : clt_pkg::CH_DEL);
						line_chars.push_back(pick_word_char(numeric));
					end
					if (shape != LINE_FULL && $urandom_range(0, 15) == 0)
						line_chars.push_back(pick_ignored());
				end
			end
			// a full line closes on its own at the last position, no return needed
			if (shape == LINE_FULL)
				while (line_chars.size() > LINE_CHARS)
					void'(line_chars.pop_back());
			else
				line_chars.push_back(clt_pkg::CH_CR);
		end
	endtask

	initial begin : stimulus
		string       words_line;
		line_shape_t shape;
		int          line_no;
		bit          no_gaps;
		arst_n     = 1'b0;
		start      = 1'b0;
		rx_char    = '0;
		row_typed  = 1'b0;
		row_result = '0;
		line_len   = 0;

		// return on an empty line gives the empty result
		add_row(clt_pkg::CH_CR, 1'b1, make_field(0, 1'b0, 0, 0, 32'd0, 0, 1'b1, 1'b1));
		// backspace on an empty line is dropped, delete on an empty line is kept,
		// a low control code is dropped and the top code is a delimiter
		add_row(clt_pkg::CH_BS);
		add_row(clt_pkg::CH_DEL);
		add_row(8'd0);
		add_row(8'd255);
		add_row(clt_pkg::CH_UPPER_A);
		add_row(clt_pkg::CH_CR, 1'b1, make_field(0, 1'b0, 2, 1, 32'd0, 1, 1'b0, 1'b1));
		// both erase codes on a non-empty line
		add_row(clt_pkg::CH_DIGIT_9);
		add_row(clt_pkg::CH_LOWER_Z);
		add_row(clt_pkg::CH_UPPER_Z);
		add_row(clt_pkg::CH_BS);
		add_row(clt_pkg::CH_DEL);
		add_row(clt_pkg::CH_CR, 1'b1, make_field(0, 1'b1, 0, 1, 32'd9, 1, 1'b0, 1'b1));
		// six fields, the last one running over a delimiter to the end
		words_line = "0 z 9 Z 3 a,d";
		for (int i = 0; i < words_line.len(); i++)
			add_row(clt_pkg::char_t'(words_line[i]));
		add_row(clt_pkg::CH_CR);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i])
			drive_char(plan[i].ch, 1'b0, plan[i].typed, plan[i].res);
		wait_for_results();

		// random lines, mostly well formed, one at full length
		line_no = 0;
		while (chars_sent < ITEMS_TOTAL) begin
			if (line_no == 2)
				shape = LINE_FULL;
			else if ($urandom_range(0, 6) == 0)
				shape = LINE_NOISE;
			else
				shape = LINE_WORDS;
			build_line(shape);
			no_gaps = ($urandom_range(0, 3) == 0);
			foreach (line_chars[i])
				drive_char(line_chars[i], no_gaps, 1'b0, '0);
			if ($urandom_range(0, 5) == 0)
				wait_for_results();
			line_no++;
		end

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("run covered %0d characters in %0d closed lines,", chars_sent, lines_closed);
		$display("%0d at full length and %0d at the field limit", full_lines, capped_lines);
		$display("%0d field results checked, %0d mismatches", results_checked, mismatches);
		if (mismatches == 0 && expected_fields.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

FILE: command_line_tokenizer_unit.f
rtl/clt_pkg.sv
rtl/clt_ram.sv
rtl/command_line_tokenizer_unit.sv
verif/testbench.sv
